// ----- hw/rtl/premultiplied_gamma_adjust_core_assert.svh -----
// assertion macros for the premultiplied gamma adjust core
`ifndef PREMULTIPLIED_GAMMA_ADJUST_CORE_ASSERT_SVH
`define PREMULTIPLIED_GAMMA_ADJUST_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define PGA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define PGA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PGA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define PGA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/pga_pkg.sv -----
// shared types and constants for the premultiplied gamma adjust core
`timescale 1ns / 1ps
`default_nettype none

package pga_pkg;

  localparam int BYTE_W     = 8;
  localparam int PIX_W      = 32;
  localparam int NUM_CH     = 3;
  localparam int TAB_DEPTH  = 256;
  localparam int TAB_AW     = 8;
  localparam int RCP_W      = 15;
  localparam int PROD_W     = RCP_W + BYTE_W;
  localparam int IN_DATA_W  = 64;
  localparam int RCP_NUM    = 65536;
  localparam int RCP_MAX    = (1 << RCP_W) - 1;

  localparam logic [BYTE_W-1:0] BYTE_MAX     = 8'hFF;
  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [BYTE_W-1:0] ALPHA_CLEAR  = 8'h00;

  typedef logic [NUM_CH-1:0][BYTE_W-1:0] chan_vec_t;

  typedef enum logic [1:0] {
    MODE_LOAD,
    MODE_OPAQUE,
    MODE_PASS,
    MODE_PARTIAL
  } mode_t;

  // item leaving the index stage, channel 2 red, 1 green, 0 blue
  typedef struct packed {
    logic              valid;
    mode_t             mode;
    logic              last;
    logic [BYTE_W-1:0] alpha;
    chan_vec_t         color;
    chan_vec_t         addr;
    chan_vec_t         wdata;
  } idx_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pga_table_ram.sv -----
// one 256 x 8 gamma table with registered read
`timescale 1ns / 1ps
`default_nettype none

module pga_table_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [pga_pkg::TAB_AW-1:0] waddr,
  input  wire logic [pga_pkg::BYTE_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [pga_pkg::TAB_AW-1:0] raddr,
  output logic      [pga_pkg::BYTE_W-1:0] rdata
);
  import pga_pkg::*;

  logic [BYTE_W-1:0] mem [TAB_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pga_index_unit.sv -----
// decode, reciprocal lookup and table index stages
`timescale 1ns / 1ps
`default_nettype none

module pga_index_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [pga_pkg::IN_DATA_W-1:0] in_data,
  input  wire logic                         in_action,
  input  wire logic                         in_last,
  input  wire logic                         down_ready,
  output pga_pkg::idx_item_t                item
);
  import pga_pkg::*;

  // reciprocal rom, constant values worked out at elaboration
  logic [RCP_W-1:0] rcp_rom [TAB_DEPTH];

  for (genvar i = 0; i < TAB_DEPTH; i++) begin : g_rcp
    localparam int DIV = (i == 0) ? 1 : i;
    localparam int QUO = RCP_NUM / DIV;
    localparam int VAL = (QUO > RCP_MAX) ? RCP_MAX : QUO;
    assign rcp_rom[i] = RCP_W'(VAL);
  end

  // input decode
  logic [BYTE_W-1:0] in_alpha;
  chan_vec_t         in_color;
  chan_vec_t         in_wdata;
  mode_t             in_mode;

  assign in_alpha = in_data[31:24];
  assign in_color = in_data[23:0];
  assign in_wdata = {in_data[47:40], in_data[55:48], in_data[63:56]};

  always_comb begin
    if (in_action) begin
      in_mode = MODE_LOAD;
    end else if (in_alpha == ALPHA_OPAQUE) begin
      in_mode = MODE_OPAQUE;
    end else if (in_alpha == ALPHA_CLEAR) begin
      in_mode = MODE_PASS;
    end else begin
      in_mode = MODE_PARTIAL;
    end
  end

  // stage 1
  logic              v1;
  mode_t             mode1;
  logic              last1;
  logic [BYTE_W-1:0] alpha1;
  chan_vec_t         color1;
  chan_vec_t         wdata1;
  logic [BYTE_W-1:0] eidx1;
  logic [RCP_W-1:0]  rcp1;

  // stage 2
  logic              v2;
  mode_t             mode2;
  logic              last2;
  logic [BYTE_W-1:0] alpha2;
  chan_vec_t         color2;
  chan_vec_t         addr2;
  chan_vec_t         wdata2;

  logic en1;
  logic en2;

  assign en2      = ~v2 | down_ready;
  assign en1      = ~v1 | en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      mode1  <= in_mode;
      last1  <= in_last;
      alpha1 <= in_alpha;
      color1 <= in_color;
      wdata1 <= in_wdata;
      eidx1  <= in_data[39:32];
      rcp1   <= rcp_rom[in_alpha];
    end
  end

  // un-premultiply index per channel
  logic [PROD_W-1:0] prod [NUM_CH];
  chan_vec_t         addr_next;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      prod[k] = rcp1 * color1[k];
      case (mode1)
        MODE_LOAD:    addr_next[k] = eidx1;
        MODE_OPAQUE:  addr_next[k] = color1[k];
        MODE_PARTIAL: addr_next[k] = (color1[k] > alpha1) ? BYTE_MAX : prod[k][15:8];
        default:      addr_next[k] = color1[k];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      mode2  <= mode1;
      last2  <= last1;
      alpha2 <= alpha1;
      color2 <= color1;
      addr2  <= addr_next;
      wdata2 <= wdata1;
    end
  end

  assign item = '{valid: v2, mode: mode2, last: last2, alpha: alpha2,
                  color: color2, addr: addr2, wdata: wdata2};

endmodule

`default_nettype wire

// ----- hw/rtl/pga_remul_unit.sv -----
// re-premultiply, saturate and output register stages
`timescale 1ns / 1ps
`default_nettype none

`include "premultiplied_gamma_adjust_core_assert.svh"

module pga_remul_unit (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  pga_pkg::idx_item_t            item,
  input  wire pga_pkg::chan_vec_t       tval,
  output logic                          up_ready,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [pga_pkg::PIX_W-1:0]     out_pixel,
  output logic                          out_last
);
  import pga_pkg::*;

  logic en3;
  logic en4;
  logic en5;

  // stage 3, table data arrives from the rams in this cycle
  logic              v3;
  mode_t             mode3;
  logic              last3;
  logic [BYTE_W-1:0] alpha3;
  chan_vec_t         color3;

  // stage 4
  logic                v4;
  mode_t               mode4;
  logic                last4;
  logic [BYTE_W-1:0]   alpha4;
  chan_vec_t           color4;
  chan_vec_t           tval4;
  chan_vec_t           excess4;
  logic [BYTE_W:0]     scaled4 [NUM_CH];

  // stage 5 is the output register
  logic v5;

  assign en5      = ~v5 | out_ready;
  assign en4      = ~v4 | en5;
  assign en3      = ~v3 | en4;
  assign up_ready = en3;

  // load items end at the table write
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= item.valid && (item.mode != MODE_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      mode3  <= item.mode;
      last3  <= item.last;
      alpha3 <= item.alpha;
      color3 <= item.color;
    end
  end

  logic [BYTE_W:0]     factor;
  logic [2*BYTE_W:0]   prod [NUM_CH];
  logic [BYTE_W:0]     scaled_next [NUM_CH];
  chan_vec_t           excess_next;

  assign factor = {1'b0, alpha3} + (BYTE_W+1)'(alpha3[BYTE_W-1]);

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      prod[k]        = tval[k] * factor;
      scaled_next[k] = prod[k][2*BYTE_W:BYTE_W];
      excess_next[k] = (color3[k] > alpha3) ? (color3[k] - alpha3) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      mode4   <= mode3;
      last4   <= last3;
      alpha4  <= alpha3;
      color4  <= color3;
      tval4   <= tval;
      excess4 <= excess_next;
      for (int k = 0; k < NUM_CH; k++) begin
        scaled4[k] <= scaled_next[k];
      end
    end
  end

  logic [BYTE_W+1:0]  sum [NUM_CH];
  chan_vec_t          sat;
  logic [PIX_W-1:0]   pixel_next;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      sum[k] = (BYTE_W+2)'(scaled4[k]) + (BYTE_W+2)'(excess4[k]);
      sat[k] = (sum[k] > (BYTE_W+2)'(BYTE_MAX)) ? BYTE_MAX : sum[k][BYTE_W-1:0];
    end
    case (mode4)
      MODE_OPAQUE:  pixel_next = {ALPHA_OPAQUE, tval4};
      MODE_PARTIAL: pixel_next = {alpha4, sat};
      default:      pixel_next = {alpha4, color4};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_pixel <= pixel_next;
      out_last  <= last4;
    end
  end

  assign out_valid = v5;

  // transparent pixels read arbitrary table entries, only partial alpha is scaled
  logic partial4;
  logic scaled_ovf;

  assign partial4   = v4 && (mode4 == MODE_PARTIAL);
  assign scaled_ovf = scaled4[0][BYTE_W] | scaled4[1][BYTE_W] | scaled4[2][BYTE_W];

  `PGA_ASSERT_IMPL(a_no_load_s3, clk, rst, v3, mode3 != MODE_LOAD, "load item past table stage")
  `PGA_ASSERT_IMPL(a_scaled_fits, clk, rst, partial4, !scaled_ovf, "scaled color above 255")
  `PGA_ASSERT_NEXT(a_stall_holds_s4, clk, rst, v4 && !en4, v4, "stalled stage 4 item lost")

endmodule

`default_nettype wire

// ----- hw/rtl/premultiplied_gamma_adjust_core.sv -----
// top level of the premultiplied argb8888 gamma adjust core
`timescale 1ns / 1ps
`default_nettype none

// usage
//   slave channel s_*: one transfer is either a pixel (s_tuser low) or a table
//   load (s_tuser high). a load writes entry s_tdata[39:32] of the red, green
//   and blue tables and gives no output. a pixel gives exactly one transfer on
//   the master channel m_*, in input order, with s_tlast copied to m_tlast.
//   the tables must be loaded before pixels use them; nothing clears them.
// throughput
//   one transfer per cycle unless m_tready stalls, pixels and loads alike; a
//   load may be directly followed by a pixel that uses the new entry, since
//   tables are written at the same pipeline stage where pixels read them.
// pipeline
//   five register stages: decode and reciprocal rom, index multiply, table
//   read, alpha multiply, saturate into the output register.
// reset
//   rst clears the valid bits of all stages, table contents are kept.
// stalls
//   each stage holds its item while the stage after it is full and blocked,
//   empty stages keep filling, so s_tready drops only when all five are full.

module premultiplied_gamma_adjust_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // pixel_in[31:0], entry_index[39:32], red_entry[47:40],
  // green_entry[55:48], blue_entry[63:56]
  input  wire logic [pga_pkg::IN_DATA_W-1:0] s_tdata,
  // action: 0 pixel, 1 table load
  input  wire logic                         s_tuser,
  input  wire logic                         s_tlast,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // pixel_out[31:0]
  output logic [pga_pkg::PIX_W-1:0]         m_tdata,
  output logic                              m_tlast
);
  import pga_pkg::*;

  idx_item_t item;        // item at the table stage input
  chan_vec_t tab_rd;      // registered table data, one byte per channel
  logic      table_ready; // table stage can take the item
  logic      table_we;

  pga_index_unit u_index (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (s_tdata),
    .in_action  (s_tuser),
    .in_last    (s_tlast),
    .down_ready (table_ready),
    .item       (item)
  );

  // loads write when they move into the table stage, pixels read there
  assign table_we = table_ready && item.valid && (item.mode == MODE_LOAD);

  for (genvar k = 0; k < NUM_CH; k++) begin : g_ch
    pga_table_ram u_ram (
      .clk   (clk),
      .we    (table_we),
      .waddr (item.addr[k]),
      .wdata (item.wdata[k]),
      .re    (table_ready),
      .raddr (item.addr[k]),
      .rdata (tab_rd[k])
    );
  end

  pga_remul_unit u_remul (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .tval      (tab_rd),
    .up_ready  (table_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pixel (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

`default_nettype wire
